// ===== design/aldi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer low-pass double integrator: shared definitions
// Widths, register indexes, fixed-point constants, the sequencer states and
// the digit step of the divide-by-25 unit.
// ----------------------------------------------------------------------------
package aldi_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CfgAccelOffset   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFilterGain    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDeadbandLevel = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgWarmupSamples = 2'd3;

  // Field and register widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned GainW   = 17;
  localparam int unsigned DeadW   = 31;
  localparam int unsigned WarmW   = 8;
  localparam int unsigned DiffW   = 17;
  localparam int unsigned AccW    = 27;
  localparam int unsigned FiltW   = 32;
  localparam int unsigned SpeedW  = 48;
  localparam int unsigned DistW   = 56;
  localparam int unsigned PosW    = 40;
  localparam int unsigned VelW    = 32;

  // Shared multiplier and accumulator
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 18;
  localparam int unsigned ProdW = 51;
  localparam int unsigned SumW  = 72;

  // Divide-by-25 unit: radix 16, one digit per cycle
  localparam int unsigned DivInW   = 48;
  localparam int unsigned DivUW    = 52;
  localparam int unsigned DivDigits = 13;
  localparam int unsigned DivCntW  = 4;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned RemW     = 5;
  localparam int unsigned StepW    = 9;

  // Reset values of the configuration registers
  localparam logic [OffsetW-1:0] OffsetReset = 16'd0;
  localparam logic [GainW-1:0]   GainReset   = 17'd6554;
  localparam logic [DeadW-1:0]   DeadReset   = 31'd4588;
  localparam logic [WarmW-1:0]   WarmReset   = 8'd10;

  // Fixed-point constants
  localparam logic [GainW-1:0]   GainOne  = 17'd65536;
  localparam logic [MulAW-1:0]   AccScale = 33'd164417;  // round(0.0098 * 2^24)
  localparam logic [MulBW-1:0]   UmScale  = 18'd15625;   // 10^6 / 2^6
  localparam logic [StepW-1:0]   DivBase  = 9'd25;
  localparam logic [DivUW-1:0]   DivBias  = 52'd25 << 46;
  localparam logic [DivInW-1:0]  QuotBias = 48'd1 << 46;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ACC,
    ST_ACC,
    ST_MUL_NEW,
    ST_FILT,
    ST_DEAD,
    ST_DV_START,
    ST_DV_WAIT,
    ST_DX_START,
    ST_DX_WAIT,
    ST_VEL_LO,
    ST_VEL_HI,
    ST_POS_LO,
    ST_POS_HI,
    ST_POS_SUM,
    ST_DONE
  } aldi_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } aldi_div_status_t;

  typedef struct packed {
    logic [DigitW-1:0] quot;
    logic [RemW-1:0]   rem;
  } aldi_dstep_t;

  // One radix-16 digit of a division by 25: the partial remainder is below 25,
  // so the partial dividend is below 400 and the digit below 16.
  function automatic aldi_dstep_t div25_step(logic [StepW-1:0] part);
    aldi_dstep_t       res;
    logic [DigitW-1:0] qd;
    logic [StepW-1:0]  sub;
    qd = '0;
    for (int k = 1; k < 16; k++) begin
      if (part >= StepW'(25 * k)) begin
        qd = DigitW'(k);
      end
    end
    sub      = StepW'(DivBase * {5'b0, qd});
    res.quot = qd;
    res.rem  = RemW'(part - sub);
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/accel_lowpass_double_integrator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer low-pass double integrator
// Offset, scaling, low-pass filter, deadband and trapezoidal integration of
// one accelerometer axis into velocity and position.
// ----------------------------------------------------------------------------
// Each input word is one raw sample in milli-g. It is offset-corrected, scaled
// to m/s^2 (2^-16 units), low-pass filtered and passed through the deadband;
// after the warm-up samples it is integrated twice into velocity (2^-24 m/s)
// and position (2^-24 m), and one result word gives position in micrometres,
// velocity in micrometres per second, the filtered acceleration and a settled
// flag. One word is worked on at a time by a small sequencer around a shared
// 33 x 18 multiplier and a radix-16 divide-by-25 unit. While warming up, a
// word skips the two divisions (13 digit steps each plus start and hand-over)
// that every word goes through once integrating. The next word is accepted
// while a result still waits on the output register.
module accel_lowpass_double_integrator_unit import aldi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SampleW-1:0]   accel_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PosW-1:0]      position_um_o,
  output logic [VelW-1:0]      velocity_um_s_o,
  output logic [FiltW-1:0]     filtered_accel_o,
  output logic                 settled_o
);

  // Configuration
  logic [OffsetW-1:0] offset_q;
  logic [GainW-1:0]   gain_q;
  logic [DeadW-1:0]   dead_q;
  logic [WarmW-1:0]   warm_q;

  // Integrator state
  logic [FiltW-1:0]   fv_q;
  logic [FiltW-1:0]   pa_q;
  logic [SpeedW-1:0]  spd_q;
  logic [SpeedW-1:0]  pspd_q;
  logic [DistW-1:0]   dist_q;
  logic [WarmW-1:0]   wcnt_q;

  // Sequencer and working registers
  aldi_state_e        state_q, state_d;
  logic [DiffW-1:0]   diff_q;
  logic [AccW-1:0]    accv_q;
  logic [ProdW-1:0]   prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [FiltW-1:0]   a_q;
  logic               run_q;
  logic [VelW-1:0]    vel_w_q;

  // Output register
  logic               out_valid_q;
  logic [PosW-1:0]    pos_q;
  logic [VelW-1:0]    vel_q;
  logic [FiltW-1:0]   filt_q;
  logic               settled_q;

  // Datapath nets
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic               div_start;
  logic [DivInW-1:0]  div_in;
  logic [DivInW-1:0]  div_q;
  aldi_div_status_t   div_st;
  logic [GainW-1:0]   g_eff, g_inv;
  logic [DiffW-1:0]   diff_d;
  logic [ProdW-1:0]   acc_rnd;
  logic [SumW-1:0]    prod_ext, prod_sh, fsum;
  logic [FiltW-1:0]   fv_sat;
  logic [FiltW:0]     mag;
  logic               dead, run_now, out_free;
  logic [FiltW:0]     asum;
  logic [DivInW-1:0]  m1, m2;
  logic [SpeedW+1:0]  ssum;
  logic [SpeedW:0]    vsum;
  logic [SpeedW-1:0]  spd_sat;
  logic [DistW:0]     dsum;
  logic [DistW-1:0]   dist_sat;
  logic [VelW-1:0]    vel_sat;
  logic [PosW-1:0]    pos_sat;

  aldi_div25 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .status_o   (div_st),
    .quotient_o (div_q)
  );

  // ---------------------------------------------------------------- datapath
  assign g_eff   = (gain_q > GainOne) ? GainOne : gain_q;
  assign g_inv   = GainOne - g_eff;
  assign diff_d  = {accel_sample_i[SampleW-1], accel_sample_i}
                 - {offset_q[OffsetW-1], offset_q};
  assign prod_d  = $signed(mul_a) * $signed(mul_b);
  assign acc_rnd = prod_q + ProdW'(128);
  assign prod_ext = {{(SumW - ProdW){prod_q[ProdW-1]}}, prod_q};
  assign prod_sh  = {prod_ext[SumW-29:0], 28'b0};
  assign fsum     = sum_q + prod_ext;
  assign out_free = !out_valid_q || !out_stall_i;
  assign run_now  = (wcnt_q >= warm_q);

  // Filter output, saturated after dropping 16 fraction bits
  always_comb begin
    if ((&fsum[SumW-1:47]) || !(|fsum[SumW-1:47])) begin
      fv_sat = fsum[47:16];
    end else begin
      fv_sat = fsum[SumW-1] ? {1'b1, {(FiltW-1){1'b0}}} : {1'b0, {(FiltW-1){1'b1}}};
    end
  end

  assign mag  = fv_q[FiltW-1] ? ((FiltW+1)'(0) - {1'b1, fv_q}) : {1'b0, fv_q};
  assign dead = (mag <= {2'b0, dead_q});

  // Velocity step: floor((64 s + 25) / 50) equals floor((32 s + 12) / 25)
  assign asum = {a_q[FiltW-1], a_q} + {pa_q[FiltW-1], pa_q};
  assign m1   = {{10{asum[FiltW]}}, asum, 5'b0} + DivInW'(12);

  // Position step: floor(n / 200) equals floor(floor(n / 8) / 25)
  assign ssum = {{2{spd_q[SpeedW-1]}}, spd_q} + {{2{pspd_q[SpeedW-1]}}, pspd_q}
              + (SpeedW+2)'(100);
  assign m2   = {ssum[SpeedW+1], ssum[SpeedW+1:3]};

  assign vsum = {spd_q[SpeedW-1], spd_q} + {div_q[DivInW-1], div_q};
  always_comb begin
    if (vsum[SpeedW] == vsum[SpeedW-1]) begin
      spd_sat = vsum[SpeedW-1:0];
    end else begin
      spd_sat = vsum[SpeedW] ? {1'b1, {(SpeedW-1){1'b0}}} : {1'b0, {(SpeedW-1){1'b1}}};
    end
  end

  assign dsum = {dist_q[DistW-1], dist_q} + {{(DistW+1-DivInW){div_q[DivInW-1]}}, div_q};
  always_comb begin
    if (dsum[DistW] == dsum[DistW-1]) begin
      dist_sat = dsum[DistW-1:0];
    end else begin
      dist_sat = dsum[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end
  end

  // Micrometre conversions: round(value * 15625 / 2^18), then saturate
  always_comb begin
    if ((&sum_q[SumW-1:49]) || !(|sum_q[SumW-1:49])) begin
      vel_sat = sum_q[49:18];
    end else begin
      vel_sat = sum_q[SumW-1] ? {1'b1, {(VelW-1){1'b0}}} : {1'b0, {(VelW-1){1'b1}}};
    end
    if ((&sum_q[SumW-1:57]) || !(|sum_q[SumW-1:57])) begin
      pos_sat = sum_q[57:18];
    end else begin
      pos_sat = sum_q[SumW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
  end

  // Accumulator: starts the filter sum from a rounding constant; the wide
  // products come in two halves, the upper half weighted by 2^28.
  always_comb begin
    case (state_q)
      ST_MUL_NEW: sum_d = prod_ext + SumW'(32768);
      ST_VEL_HI:  sum_d = prod_ext + SumW'(131072);
      ST_POS_LO:  sum_d = sum_q + prod_sh;
      ST_POS_HI:  sum_d = prod_ext + SumW'(131072);
      ST_POS_SUM: sum_d = sum_q + prod_sh;
      default:    sum_d = sum_q;
    endcase
  end

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL_ACC;
      ST_MUL_ACC:  state_d = ST_ACC;
      ST_ACC:      state_d = ST_MUL_NEW;
      ST_MUL_NEW:  state_d = ST_FILT;
      ST_FILT:     state_d = ST_DEAD;
      ST_DEAD:     state_d = run_now ? ST_DV_START : ST_VEL_LO;
      ST_DV_START: state_d = ST_DV_WAIT;
      ST_DV_WAIT:  if (div_st.done) state_d = ST_DX_START;
      ST_DX_START: state_d = ST_DX_WAIT;
      ST_DX_WAIT:  if (div_st.done) state_d = ST_VEL_LO;
      ST_VEL_LO:   state_d = ST_VEL_HI;
      ST_VEL_HI:   state_d = ST_POS_LO;
      ST_POS_LO:   state_d = ST_POS_HI;
      ST_POS_HI:   state_d = ST_POS_SUM;
      ST_POS_SUM:  state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_in     = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_MUL_ACC: begin
        mul_a = AccScale;
        mul_b = {diff_q[DiffW-1], diff_q};
      end
      ST_ACC: begin
        mul_a = {fv_q[FiltW-1], fv_q};
        mul_b = {1'b0, g_inv};
      end
      ST_MUL_NEW: begin
        mul_a = {{(MulAW - AccW){accv_q[AccW-1]}}, accv_q};
        mul_b = {1'b0, g_eff};
      end
      ST_DV_START: begin
        div_start = 1'b1;
        div_in    = m1;
      end
      ST_DX_START: begin
        div_start = 1'b1;
        div_in    = m2;
      end
      ST_VEL_LO: begin
        mul_a = {5'b0, spd_q[27:0]};
        mul_b = UmScale;
      end
      ST_VEL_HI: begin
        mul_a = {{13{spd_q[SpeedW-1]}}, spd_q[SpeedW-1:28]};
        mul_b = UmScale;
      end
      ST_POS_LO: begin
        mul_a = {5'b0, dist_q[27:0]};
        mul_b = UmScale;
      end
      ST_POS_HI: begin
        mul_a = {{5{dist_q[DistW-1]}}, dist_q[DistW-1:28]};
        mul_b = UmScale;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------ control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      offset_q    <= OffsetReset;
      gain_q      <= GainReset;
      dead_q      <= DeadReset;
      warm_q      <= WarmReset;
      fv_q        <= '0;
      pa_q        <= '0;
      spd_q       <= '0;
      pspd_q      <= '0;
      dist_q      <= '0;
      wcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgAccelOffset:   offset_q <= cfg_data_i[OffsetW-1:0];
          CfgFilterGain:    gain_q   <= cfg_data_i[GainW-1:0];
          CfgDeadbandLevel: dead_q   <= cfg_data_i[DeadW-1:0];
          CfgWarmupSamples: warm_q   <= cfg_data_i[WarmW-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_FILT) begin
        fv_q <= fv_sat;
      end
      // Inside the deadband the speed is cleared even during warm-up.
      if (state_q == ST_DEAD) begin
        if (dead) begin
          spd_q <= '0;
        end
        if (!run_now) begin
          wcnt_q <= wcnt_q + 1'b1;
        end
      end
      if (state_q == ST_DV_WAIT && div_st.done) begin
        spd_q <= spd_sat;
        pa_q  <= a_q;
      end
      if (state_q == ST_DX_WAIT && div_st.done) begin
        dist_q <= dist_sat;
        pspd_q <= spd_q;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    if (in_valid_i && !in_stall_o) begin
      diff_q <= diff_d;
    end
    if (state_q == ST_ACC) begin
      accv_q <= acc_rnd[AccW+7:8];
    end
    if (state_q == ST_DEAD) begin
      a_q   <= dead ? '0 : fv_q;
      run_q <= run_now;
    end
    if (state_q == ST_POS_HI) begin
      vel_w_q <= vel_sat;
    end
    if (state_q == ST_DONE && out_free) begin
      pos_q     <= pos_sat;
      vel_q     <= vel_w_q;
      filt_q    <= a_q;
      settled_q <= run_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_um_o    = pos_q;
  assign velocity_um_s_o  = vel_q;
  assign filtered_accel_o = filt_q;
  assign settled_o        = settled_q;

  // ------------------------------------------------------------- assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_MUL_ACC)
    else $error("accepted word did not start the sequence");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_DV_WAIT || state_q == ST_DX_WAIT))
    else $error("divider finished while nothing waited for it");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_st.busy)
    else $error("divider busy while the sequencer is idle");

  a_settled_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && settled_o |-> wcnt_q >= warm_q)
    else $error("settled word reported before warm-up completed");

endmodule
`default_nettype wire

// ===== design/aldi_div25.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divide-by-25 unit
// Floor division of a signed 48-bit value by 25, one radix-16 digit a cycle.
// ----------------------------------------------------------------------------
module aldi_div25 import aldi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DivInW-1:0]       dividend_i,
  output aldi_div_status_t        status_o,
  output logic [DivInW-1:0]       quotient_o
);

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivDigits - 1);

  logic [DivUW-1:0]   u_q;
  logic [DivInW-1:0]  q_q;
  logic [RemW-1:0]    rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  aldi_dstep_t        step;

  assign step = div25_step({rem_q, u_q[DivUW-1 -: DigitW]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A bias of 25 * 2^46 makes the dividend non-negative, so plain long
  // division gives the floor; the bias comes off the quotient as 2^46.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q   <= {{(DivUW - DivInW){dividend_i[DivInW-1]}}, dividend_i} + DivBias;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      u_q   <= {u_q[DivUW-DigitW-1:0], {DigitW{1'b0}}};
      rem_q <= step.rem;
      q_q   <= {q_q[DivInW-DigitW-1:0], step.quot};
    end
  end

  assign quotient_o    = q_q - QuotBias;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer low-pass double integrator: regression bench
// Raw samples are driven through the valid/stall input channel. Each accepted
// word is run through a fixed-point model of the offset, scaling, filter,
// deadband and trapezoidal integration. The result words are checked field by
// field, in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import aldi_pkg::*;

  localparam longint MilliGScale    = 164417;  // 0.0098 m/s^2 per milli-g, 2^24 scaled
  localparam longint GainUnity      = 65536;
  localparam longint MicroScale     = 15625;
  localparam int     WatchdogLimit  = 4000;
  localparam int     DrainCycles    = 60;
  localparam int     LongHoldCycles = 400;

  typedef struct packed {
    logic [PosW-1:0]  position_um;
    logic [VelW-1:0]  velocity_um_s;
    logic [FiltW-1:0] filtered_accel;
    logic             settled;
  } motion_word_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  accel_sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [PosW-1:0]     position_um_o;
  logic [VelW-1:0]     velocity_um_s_o;
  logic [FiltW-1:0]    filtered_accel_o;
  logic                settled_o;

  // Register copies and integrator state of the predictor.
  logic [OffsetW-1:0] offset_mirror = 16'd0;
  logic [GainW-1:0]   gain_mirror   = 17'd6554;
  logic [DeadW-1:0]   dead_mirror   = 31'd4588;
  logic [WarmW-1:0]   warm_mirror   = 8'd10;
  longint             filt_state    = 0;
  longint             last_accel    = 0;
  longint             speed_state   = 0;
  longint             last_speed    = 0;
  longint             dist_state    = 0;
  int                 warm_count    = 0;

  logic [SampleW-1:0] sample_queue[$];
  motion_word_t       expected_words[$];

  int unsigned mismatches        = 0;
  int unsigned gap_left          = 0;
  int unsigned stall_left        = 0;
  int unsigned hold_left         = 0;
  int unsigned idle_cycles       = 0;
  bit          steady            = 1'b0;
  bit          long_hold_request = 1'b0;
  bit          long_hold_taken   = 1'b0;

  accel_lowpass_double_integrator_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .accel_sample_i   (accel_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_um_o    (position_um_o),
    .velocity_um_s_o  (velocity_um_s_o),
    .filtered_accel_o (filtered_accel_o),
    .settled_o        (settled_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint floor_div(longint num, longint den);
    longint quot;
    quot = num / den;
    if ((num % den) != 0 && num < 0) begin
      quot = quot - 1;
    end
    return quot;
  endfunction

  function automatic longint clamp(longint value, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (value > hi) begin
      return hi;
    end
    if (value < -hi - 1) begin
      return -hi - 1;
    end
    return value;
  endfunction

  // 2^-24 units to micro units, split so that the product cannot overflow.
  function automatic longint to_micro(longint value);
    longint quot;
    quot = floor_div(value, 262144);
    return quot * MicroScale + floor_div((value - quot * 262144) * MicroScale + 131072, 262144);
  endfunction

  function automatic motion_word_t integrate_sample(logic [SampleW-1:0] raw);
    motion_word_t word;
    longint       acc;
    longint       g;
    longint       a;
    longint       mag;
    logic         run;
    acc = floor_div((longint'($signed(raw)) - longint'($signed(offset_mirror))) * MilliGScale
                    + 128, 256);
    g = (gain_mirror > 17'd65536) ? GainUnity : longint'(gain_mirror);
    filt_state = clamp(floor_div(filt_state * (GainUnity - g) + acc * g + 32768, GainUnity), 32);
    a = filt_state;
    mag = (a < 0) ? -a : a;
    // Inside the deadband the body is taken as still; the filter keeps its value.
    if (mag <= longint'(dead_mirror)) begin
      speed_state = 0;
      a = 0;
    end
    run = (warm_count >= int'(warm_mirror));
    if (run) begin
      speed_state = clamp(speed_state + floor_div((a + last_accel) * 64 + 25, 50), SpeedW);
      dist_state  = clamp(dist_state + floor_div(speed_state + last_speed + 100, 200), DistW);
      last_accel  = a;
      last_speed  = speed_state;
    end else begin
      warm_count++;
    end
    word.position_um    = PosW'(clamp(to_micro(dist_state), PosW));
    word.velocity_um_s  = VelW'(clamp(floor_div(speed_state * MicroScale + 131072, 262144),
                                      VelW));
    word.filtered_accel = FiltW'(a);
    word.settled        = run;
    return word;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(1, 3);
    end
    if (pick < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAccelOffset:   offset_mirror = data[OffsetW-1:0];
      CfgFilterGain:    gain_mirror   = data[GainW-1:0];
      CfgDeadbandLevel: dead_mirror   = data[DeadW-1:0];
      CfgWarmupSamples: warm_mirror   = data[WarmW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || expected_words.size() != 0);
  endtask

  // Sender: offers the next queued sample after an optional gap.
  always @(posedge clk_i) begin : tx_side
    logic next_valid;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(integrate_sample(accel_sample_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_queue.size() != 0) begin
          next_valid = 1'b1;
          accel_sample_i <= sample_queue.pop_front();
          if (!steady && $urandom_range(0, 3) == 0) begin
            gap_left = idle_length();
          end
        end
        in_valid_i <= next_valid;
      end
    end
  end

  // Receiver: checks each accepted result word and stalls at random.
  always @(posedge clk_i) begin : rx_side
    motion_word_t want;
    logic         next_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word expected none actual position_um %0h", $time,
                   position_um_o);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          compare_field("position_um", want.position_um, position_um_o);
          compare_field("velocity_um_s", want.velocity_um_s, velocity_um_s_o);
          compare_field("filtered_accel", want.filtered_accel, filtered_accel_o);
          compare_field("settled", want.settled, settled_o);
        end
      end
      if (long_hold_request && !long_hold_taken) begin
        hold_left       = LongHoldCycles;
        long_hold_taken = 1'b1;
      end
      next_stall = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = idle_length() - 1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
      $display("accel_lowpass_double_integrator_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SampleW-1:0] level;
    logic [GainW-1:0]   gain_pick;
    logic [WarmW-1:0]   warm_pick;
    int unsigned        mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Settings after reset: warm-up with both full-scale extremes and values around zero.
    sample_queue = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff};

    // Warm-up lowered below the count already reached, gain above one, smallest offset,
    // and a zero deadband that only a filtered value of exactly zero falls into.
    wait_idle();
    write_reg(CfgWarmupSamples, 31'd3);
    write_reg(CfgFilterGain, 31'h1ffff);
    write_reg(CfgAccelOffset, 31'h8000);
    write_reg(CfgDeadbandLevel, 31'd0);
    @(negedge clk_i);
    sample_queue = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff};

    // Warm-up raised again with everything inside the deadband: speed is cleared
    // while warming up.
    wait_idle();
    write_reg(CfgWarmupSamples, 31'd255);
    write_reg(CfgFilterGain, 31'd65537);
    write_reg(CfgAccelOffset, 31'h7fff);
    write_reg(CfgDeadbandLevel, 31'h7fffffff);
    @(negedge clk_i);
    sample_queue = '{16'h8000, 16'h7fff, 16'h0000};

    // Zero gain freezes the filter.
    wait_idle();
    write_reg(CfgWarmupSamples, 31'd0);
    write_reg(CfgDeadbandLevel, 31'd4588);
    write_reg(CfgAccelOffset, 31'd0);
    write_reg(CfgFilterGain, 31'd0);
    @(negedge clk_i);
    sample_queue = '{16'd1000, -16'sd1000};

    // Unity gain with the deadband set exactly on the scaled value of 100 milli-g.
    wait_idle();
    write_reg(CfgFilterGain, 31'd65536);
    write_reg(CfgDeadbandLevel, 31'd64225);
    @(negedge clk_i);
    sample_queue = '{16'd100, 16'd101, -16'sd100};

    // Full-scale positive ramp until the velocity output saturates. The receiver holds
    // off for a long stretch at the start so that the input side backs up.
    wait_idle();
    write_reg(CfgAccelOffset, 31'h8000);
    write_reg(CfgDeadbandLevel, 31'd0);
    @(negedge clk_i);
    long_hold_request = 1'b1;
    for (int n = 0; n < 350; n++) begin
      sample_queue.push_back(16'($urandom_range(32300, 32767)));
    end

    // Negative ramp with no idling. The first word sits on the offset, so the
    // deadband clears the speed before the ramp starts.
    wait_idle();
    write_reg(CfgAccelOffset, 31'h7fff);
    @(negedge clk_i);
    steady = 1'b1;
    sample_queue.push_back(16'h7fff);
    for (int n = 1; n < 350; n++) begin
      sample_queue.push_back(16'h8000 + 16'($urandom_range(0, 468)));
    end

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      steady = (p == 6);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        gain_pick = 17'd0;
      end else if (mode == 1) begin
        gain_pick = 17'd65536;
      end else if (mode == 2) begin
        gain_pick = 17'($urandom_range(65537, 131071));
      end else begin
        gain_pick = 17'($urandom_range(1, 65535));
      end
      warm_pick = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      // The bits above each register's width are ignored, so they carry noise.
      write_reg(CfgAccelOffset, CfgDataW'($urandom));
      write_reg(CfgFilterGain, {14'($urandom), gain_pick});
      write_reg(CfgDeadbandLevel, CfgDataW'($urandom >> $urandom_range(1, 32)));
      write_reg(CfgWarmupSamples, {23'($urandom), warm_pick});
      @(negedge clk_i);
      for (int n = 0; n < 24; n++) begin
        if (n % 8 == 0) begin
          mode  = $urandom_range(0, 2);
          level = 16'($urandom);
        end
        case (mode)
          0: sample_queue.push_back(16'($urandom));
          1: sample_queue.push_back(offset_mirror + 16'($urandom_range(0, 32)) - 16'd16);
          default: sample_queue.push_back(level + 16'($urandom_range(0, 255)) - 16'd128);
        endcase
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d result words expected actual none", $time, expected_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("accel_lowpass_double_integrator_unit regression: pass");
    end else begin
      $display("accel_lowpass_double_integrator_unit regression: fail");
    end
    $finish;
  end

endmodule
